// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/hrhs_pkg.sv -----
// ----------------------------------------------------------------------------
// hrhs_pkg
// Character codes, phase codes and register map of the response scanner.
// ----------------------------------------------------------------------------
package hrhs_pkg;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'd32;

  // header match phases
  localparam logic [1:0] PH_MATCH = 2'd0;
  localparam logic [1:0] PH_SKIP  = 2'd1;
  localparam logic [1:0] PH_COPY  = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  // status code phases; digits one to three in between
  localparam logic [2:0] ST_SEEK = 3'd0;
  localparam logic [2:0] ST_D1   = 3'd1;
  localparam logic [2:0] ST_D2   = 3'd2;
  localparam logic [2:0] ST_D3   = 3'd3;
  localparam logic [2:0] ST_OK   = 3'd4;
  localparam logic [2:0] ST_BAD  = 3'd5;

  // register index, taken from paddr[4:3]
  localparam logic [1:0] REG_HEADER_NAME = 2'd0;
  localparam logic [1:0] REG_NAME_LENGTH = 2'd1;
  localparam logic [1:0] REG_VALUE_LIMIT = 2'd2;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_UP_A && c <= CH_UP_Z) r = c + CASE_OFS;
    return r;
  endfunction

endpackage

// ----- hw/rtl/http_response_header_scanner.sv -----
// ----------------------------------------------------------------------------
// http_response_header_scanner
// Per-byte HTTP response scanner: status code, body offset, header value.
// ----------------------------------------------------------------------------
// One response byte is accepted per clock, back to back, while in_stall is
// low, and each accepted beat yields exactly one registered result beat.
// The result is formed combinationally from the byte and the parser state
// registers (status digits, CRLF tracker, name match mask, value counter);
// it sits in an output register backed by one skid entry, so one more input
// beat is taken while a result waits before in_stall rises. Value bytes
// of the first header whose name matches header_name (case-insensitive,
// up to name_length chars, then a colon) stream out with value_valid;
// value_end marks the end of that value. The beat for the byte flagged
// last carries the summary and resets the parser.
// Registers sit at byte addresses 0, 8 and 16 of a 64-bit APB-style port.
`include "assert_macros.svh"

module http_response_header_scanner #(
  parameter int MAX_RESPONSE = 65536,
  parameter int NAME_CHARS   = 8,
  localparam int POS_W       = $clog2(MAX_RESPONSE + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  // byte input
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_response_byte,
  input  logic             in_last_byte,
  // results
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_value_valid,
  output logic [7:0]       out_value_byte,
  output logic             out_value_end,
  output logic             out_summary_valid,
  output logic [9:0]       out_status_number,
  output logic             out_body_found,
  output logic [POS_W-1:0] out_body_offset,
  output logic             out_header_found,
  // configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [63:0]      pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  localparam int MW = NAME_CHARS + 2;

  typedef struct packed {
    logic             value_valid;
    logic [7:0]       value_byte;
    logic             value_end;
    logic             summary_valid;
    logic [9:0]       status_number;
    logic             body_found;
    logic [POS_W-1:0] body_offset;
    logic             header_found;
  } res_t;

  // ---------------- configuration ----------------
  logic [63:0] header_name_r;
  logic [3:0]  name_length_r;
  logic [7:0]  value_limit_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_name_r <= '0;
      name_length_r <= 4'd8;
      value_limit_r <= 8'd255;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        hrhs_pkg::REG_HEADER_NAME: header_name_r <= pwdata;
        hrhs_pkg::REG_NAME_LENGTH: name_length_r <= pwdata[3:0];
        hrhs_pkg::REG_VALUE_LIMIT: value_limit_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      hrhs_pkg::REG_HEADER_NAME: prdata = header_name_r;
      hrhs_pkg::REG_NAME_LENGTH: prdata = {60'd0, name_length_r};
      hrhs_pkg::REG_VALUE_LIMIT: prdata = {56'd0, value_limit_r};
      default:                   prdata = '0;
    endcase
  end

  // ---------------- parser state ----------------
  logic [POS_W-1:0] byte_pos_r,     byte_pos_nxt;
  logic [2:0]       status_ph_r,    status_ph_nxt;
  logic [9:0]       status_acc_r,   status_acc_nxt;
  logic [1:0]       crlf_r,         crlf_nxt;
  logic             body_seen_r,    body_seen_nxt;
  logic [POS_W-1:0] body_pos_r,     body_pos_nxt;
  logic             line_start_r,   line_start_nxt;
  logic [MW-1:0]    mask_r,         mask_nxt;
  logic [1:0]       match_ph_r,     match_ph_nxt;
  logic [7:0]       value_cnt_r,    value_cnt_nxt;
  logic             hdr_matched_r,  hdr_matched_nxt;

  logic             accept;
  res_t             res;

  logic [3:0]       nl;
  logic [7:0]       lim1;
  logic             examined;
  logic             hit;
  logic [MW-1:0]    cand;
  logic [7:0]       b;
  logic [7:0]       b_low;
  logic [7:0]       want;

  assign accept = in_valid && !in_stall;
  assign b      = in_response_byte;
  assign b_low  = hrhs_pkg::to_lower(b);
  assign nl     = (name_length_r > 4'(NAME_CHARS)) ? 4'(NAME_CHARS) : name_length_r;
  assign lim1   = (value_limit_r == 8'd0) ? 8'd0 : value_limit_r - 8'd1;
  assign examined = byte_pos_r < POS_W'(MAX_RESPONSE);
  assign cand   = mask_r | {{(MW-1){1'b0}}, line_start_r};
  assign want   = crlf_r[0] ? hrhs_pkg::CH_LF : hrhs_pkg::CH_CR;

  always_comb begin
    hit = 1'b0;
    for (int k = 0; k <= NAME_CHARS; k++) begin
      if (4'(k) == nl) hit = mask_r[k+1];
    end
  end

  always_comb begin
    byte_pos_nxt    = byte_pos_r;
    status_ph_nxt   = status_ph_r;
    status_acc_nxt  = status_acc_r;
    crlf_nxt        = crlf_r;
    body_seen_nxt   = body_seen_r;
    body_pos_nxt    = body_pos_r;
    line_start_nxt  = line_start_r;
    mask_nxt        = mask_r;
    match_ph_nxt    = match_ph_r;
    value_cnt_nxt   = value_cnt_r;
    hdr_matched_nxt = hdr_matched_r;
    res             = '0;

    if (examined) begin
      // header match / value copy
      if (!body_seen_r && match_ph_r != hrhs_pkg::PH_DONE &&
          !(match_ph_r == hrhs_pkg::PH_MATCH && hdr_matched_r)) begin
        if (match_ph_nxt == hrhs_pkg::PH_MATCH) begin
          if (hit) begin
            // colon came on the previous byte; this byte starts the value
            hdr_matched_nxt = 1'b1;
            mask_nxt        = '0;
            if (lim1 == 8'd0) begin
              match_ph_nxt  = hrhs_pkg::PH_DONE;
              res.value_end = 1'b1;
            end else begin
              match_ph_nxt  = hrhs_pkg::PH_SKIP;
            end
          end else begin
            mask_nxt = '0;
            for (int k = 0; k < NAME_CHARS; k++) begin
              if (cand[k] && 4'(k) < nl &&
                  b_low == hrhs_pkg::to_lower(header_name_r[8*k +: 8]))
                mask_nxt[k+1] = 1'b1;
            end
            // whole name seen: a colon has to follow
            for (int k = 0; k <= NAME_CHARS; k++) begin
              if (cand[k] && 4'(k) == nl && b == hrhs_pkg::CH_COLON)
                mask_nxt[k+1] = 1'b1;
            end
          end
        end
        if (match_ph_nxt == hrhs_pkg::PH_SKIP) begin
          if (b != hrhs_pkg::CH_SPACE && b != hrhs_pkg::CH_TAB)
            match_ph_nxt = hrhs_pkg::PH_COPY;
        end
        if (match_ph_nxt == hrhs_pkg::PH_COPY) begin
          if (b == hrhs_pkg::CH_CR || b == hrhs_pkg::CH_LF) begin
            match_ph_nxt  = hrhs_pkg::PH_DONE;
            res.value_end = 1'b1;
          end else begin
            res.value_valid = 1'b1;
            res.value_byte  = b;
            value_cnt_nxt   = value_cnt_r + 8'd1;
            if (value_cnt_nxt >= lim1) begin
              match_ph_nxt  = hrhs_pkg::PH_DONE;
              res.value_end = 1'b1;
            end
          end
        end
      end

      // status code
      case (status_ph_r)
        hrhs_pkg::ST_SEEK: begin
          if (b == hrhs_pkg::CH_SPACE) status_ph_nxt = hrhs_pkg::ST_D1;
        end
        hrhs_pkg::ST_D1, hrhs_pkg::ST_D2, hrhs_pkg::ST_D3: begin
          if (b >= hrhs_pkg::CH_ZERO && b <= hrhs_pkg::CH_NINE) begin
            status_acc_nxt = {status_acc_r[6:0], 3'b000} + {status_acc_r[8:0], 1'b0}
                             + {6'd0, b[3:0]};
            status_ph_nxt  = status_ph_r + 3'd1;
          end else begin
            status_ph_nxt  = hrhs_pkg::ST_BAD;
          end
        end
        default: ;
      endcase

      // CRLFCRLF tracker
      if (!body_seen_r) begin
        if (b == want) begin
          if (crlf_r == 2'd3) begin
            body_seen_nxt = 1'b1;
            body_pos_nxt  = byte_pos_r + POS_W'(1);
            crlf_nxt      = 2'd0;
          end else begin
            crlf_nxt      = crlf_r + 2'd1;
          end
        end else begin
          crlf_nxt = (b == hrhs_pkg::CH_CR) ? 2'd1 : 2'd0;
        end
      end

      line_start_nxt = (b == hrhs_pkg::CH_LF);
      byte_pos_nxt   = byte_pos_r + POS_W'(1);
    end

    if (in_last_byte) begin
      // value cut short by end of data
      if (match_ph_nxt == hrhs_pkg::PH_SKIP || match_ph_nxt == hrhs_pkg::PH_COPY) begin
        match_ph_nxt  = hrhs_pkg::PH_DONE;
        res.value_end = 1'b1;
      end
      res.summary_valid = 1'b1;
      res.status_number = (status_ph_nxt == hrhs_pkg::ST_OK) ? status_acc_nxt : 10'd0;
      res.body_found    = body_seen_nxt;
      res.body_offset   = body_seen_nxt ? body_pos_nxt : '0;
      res.header_found  = hdr_matched_nxt;

      byte_pos_nxt    = '0;
      status_ph_nxt   = hrhs_pkg::ST_SEEK;
      status_acc_nxt  = '0;
      crlf_nxt        = '0;
      body_seen_nxt   = 1'b0;
      body_pos_nxt    = '0;
      line_start_nxt  = 1'b1;
      mask_nxt        = '0;
      match_ph_nxt    = hrhs_pkg::PH_MATCH;
      value_cnt_nxt   = '0;
      hdr_matched_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r    <= '0;
      status_ph_r   <= hrhs_pkg::ST_SEEK;
      status_acc_r  <= '0;
      crlf_r        <= '0;
      body_seen_r   <= 1'b0;
      body_pos_r    <= '0;
      line_start_r  <= 1'b1;
      mask_r        <= '0;
      match_ph_r    <= hrhs_pkg::PH_MATCH;
      value_cnt_r   <= '0;
      hdr_matched_r <= 1'b0;
    end else if (accept) begin
      byte_pos_r    <= byte_pos_nxt;
      status_ph_r   <= status_ph_nxt;
      status_acc_r  <= status_acc_nxt;
      crlf_r        <= crlf_nxt;
      body_seen_r   <= body_seen_nxt;
      body_pos_r    <= body_pos_nxt;
      line_start_r  <= line_start_nxt;
      mask_r        <= mask_nxt;
      match_ph_r    <= match_ph_nxt;
      value_cnt_r   <= value_cnt_nxt;
      hdr_matched_r <= hdr_matched_nxt;
    end
  end

  // ---------------- output register + skid ----------------
  logic out_valid_r;
  logic skid_valid_r;
  res_t out_res_r;
  res_t skid_res_r;

  assign in_stall = skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_res_r <= skid_valid_r ? skid_res_r : res;
    end else if (accept) begin
      skid_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_value_valid   = out_res_r.value_valid;
  assign out_value_byte    = out_res_r.value_byte;
  assign out_value_end     = out_res_r.value_end;
  assign out_summary_valid = out_res_r.summary_valid;
  assign out_status_number = out_res_r.status_number;
  assign out_body_found    = out_res_r.body_found;
  assign out_body_offset   = out_res_r.body_offset;
  assign out_header_found  = out_res_r.header_found;

  // ---------------- checks ----------------
  `ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r,
               "skid full with empty output")
  `ASSERT_NEXT(a_last_clears, clk, rst_n, accept && in_last_byte,
               byte_pos_r == '0 && !hdr_matched_r, "parser not cleared after last beat")
  `ASSERT_IMPL(a_copy_needs_match, clk, rst_n,
               match_ph_r == hrhs_pkg::PH_SKIP || match_ph_r == hrhs_pkg::PH_COPY,
               hdr_matched_r, "value phase without a match")
  `ASSERT_IMPL(a_body_pos, clk, rst_n, body_seen_r,
               body_pos_r != '0 && body_pos_r <= byte_pos_r, "body offset out of range")

endmodule
